// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used in the texel address block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cfta_pkg.sv -----
// ----------------------------------------------------------------------------
// cfta_pkg
// Shared widths, types, register codes and the warp table of the cube face
// texel address generator.
// ----------------------------------------------------------------------------
package cfta_pkg;

    // Fixed point format of face coordinates.
    localparam int FRAC_BITS = 16;
    localparam int U_W       = FRAC_BITS + 1;
    localparam logic [U_W-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [U_W-1:0] HALF_Q = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // Field and register widths.
    localparam int POS_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int ISX_W       = 15;
    localparam int ISY_W       = 14;
    localparam int BPT_W       = 3;
    localparam int FSEL_W      = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int EXT_W       = 13;
    localparam int ORGX_W      = 15;
    localparam int ORGY_W      = 14;
    localparam int COL_W       = 15;
    localparam int ROW_W       = 14;
    localparam int LIN_W       = 30;
    localparam int DEST_W      = 26;
    localparam int SRC_OFF_W   = 30;
    localparam int SRC_CR_W    = 14;

    localparam int MAX_FACE_SIZE = 4096;

    // Reset values of the registers.
    localparam logic [SIZE_W-1:0] RST_FACE_SIZE = SIZE_W'(256);
    localparam logic [ISX_W-1:0]  RST_IMAGE_X   = ISX_W'(1024);
    localparam logic [ISY_W-1:0]  RST_IMAGE_Y   = ISY_W'(768);
    localparam logic [BPT_W-1:0]  RST_BPT       = BPT_W'(4);

    // Division by three: floor(v * 43691 / 2^17) is exact for v below 2^17.
    localparam int DIV3_W     = 16;
    localparam int DIV3_SHIFT = 17;
    localparam logic [DIV3_W-1:0] DIV3_RECIP = DIV3_W'(43691);
    localparam logic [EXT_W-1:0]  RST_EXT_Y  = EXT_W'(256);

    // Fraction division: DIV_STEPS quotient bits per pipeline slice.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_SLICES = FRAC_BITS / DIV_STEPS;

    // Pipeline stage map.
    localparam int STG_WARP   = DIV_SLICES;
    localparam int STG_ADDR   = DIV_SLICES + 2;
    localparam int NUM_STAGES = DIV_SLICES + 5;

    // Warp table: entries 0..WARP_ENTRIES of f(k/N), N a power of two.
    localparam int WARP_ENTRIES = 1024;
    localparam int WARP_LOG2    = $clog2(WARP_ENTRIES);
    localparam int WARP_ADDR_W  = WARP_LOG2 + 1;
    localparam int WARP_SHIFT   = FRAC_BITS - WARP_LOG2;

    localparam longint unsigned K_SCALE_Q30 = 64'd1269470662;
    localparam longint unsigned K_GAIN_Q30  = 64'd1235983395;
    localparam int CORDIC_STEPS = 30;
    localparam int ATAN_TAB_N   = 10;
    localparam longint ATAN_Q30 [0:ATAN_TAB_N-1] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FACE_SELECT  = 3'd0,
        REG_FACE_SIZE_X  = 3'd1,
        REG_FACE_SIZE_Y  = 3'd2,
        REG_IMAGE_SIZE_X = 3'd3,
        REG_IMAGE_SIZE_Y = 3'd4,
        REG_BYTES_TEXEL  = 3'd5,
        REG_WARP_ENABLE  = 3'd6
    } reg_index_t;

    // Faces, named by their place in the cross.
    typedef enum logic [FSEL_W-1:0] {
        FACE_RIGHT  = 3'd0,
        FACE_LEFT   = 3'd1,
        FACE_TOP    = 3'd2,
        FACE_BOTTOM = 3'd3,
        FACE_FRONT  = 3'd4,
        FACE_BACK   = 3'd5
    } face_t;

    typedef struct packed {
        logic [SIZE_W-1:0] face_size_x;
        logic [SIZE_W-1:0] div_size_x;
        logic [SIZE_W-1:0] div_size_y;
        logic [EXT_W-1:0]  ext_x;
        logic [EXT_W-1:0]  ext_y;
        logic [ORGX_W-1:0] org_x;
        logic [ORGY_W-1:0] org_y;
        logic [ISX_W-1:0]  image_size_x;
        logic [BPT_W-1:0]  bytes_per_texel;
        logic              warp_enable;
    } cfg_t;

    typedef struct packed {
        logic                 sat;
        logic [POS_W-1:0]     rem;
        logic [FRAC_BITS-1:0] quo;
    } div_axis_t;

    typedef struct packed {
        div_axis_t x;
        div_axis_t y;
    } div_t;

    typedef logic [U_W-1:0] warp_lut_t [0:WARP_ENTRIES];

    // DIV_STEPS restoring steps of rem * 2^k / s, with rem below s.
    function automatic div_axis_t div_steps(div_axis_t d, logic [SIZE_W-1:0] s);
        div_axis_t      r;
        logic [POS_W:0] dbl;
        logic           ge;
        int             i;
        r = d;
        for (i = 0; i < DIV_STEPS; i++) begin
            dbl   = {r.rem, 1'b0};
            ge    = (dbl >= s);
            r.rem = ge ? POS_W'(dbl - s) : dbl[POS_W-1:0];
            r.quo = {r.quo[FRAC_BITS-2:0], ge};
        end
        return r;
    endfunction

    // Table of atan(1.18228668555*t)*1.151099238 in Q1.FRAC_BITS, built at
    // elaboration with an integer CORDIC in Q30 and rounded half up.
    function automatic warp_lut_t build_warp_lut();
        warp_lut_t       lut;
        longint          x;
        longint          y;
        longint          z;
        longint          ang;
        longint          a;
        longint          dx;
        longint          dy;
        longint unsigned v;
        int              k;
        int              i;
        for (k = 0; k <= WARP_ENTRIES; k++) begin
            z   = longint'((longint'(k) * K_SCALE_Q30) / WARP_ENTRIES);
            x   = 64'sd1 << 30;
            y   = z;
            ang = 0;
            for (i = 0; i < CORDIC_STEPS; i++) begin
                if (i < ATAN_TAB_N) begin
                    a = ATAN_Q30[i];
                end
                else begin
                    a = 64'sd1 << (30 - i);
                end
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x   = x + dx;
                    y   = y - dy;
                    ang = ang + a;
                end
                else begin
                    x   = x - dx;
                    y   = y + dy;
                    ang = ang - a;
                end
            end
            if (ang < 0) begin
                ang = 0;
            end
            v = (longint'(ang) * K_GAIN_Q30 + (64'd1 << (59 - FRAC_BITS)))
                >> (60 - FRAC_BITS);
            lut[k] = (v > longint'(ONE_Q)) ? ONE_Q : v[U_W-1:0];
        end
        return lut;
    endfunction

    localparam warp_lut_t WARP_LUT = build_warp_lut();

endpackage

// ----- hdl/cfta_if.sv -----
// ----------------------------------------------------------------------------
// cfta_req_if / cfta_rsp_if
// Valid/ready channels for destination texels and the resulting addresses.
// ----------------------------------------------------------------------------
interface cfta_req_if;
    logic                         valid;
    logic                         ready;
    logic [cfta_pkg::POS_W-1:0]   dest_col;
    logic [cfta_pkg::POS_W-1:0]   dest_row;

    modport source (output valid, output dest_col, output dest_row, input ready);
    modport sink (input valid, input dest_col, input dest_row, output ready);
endinterface

interface cfta_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [cfta_pkg::DEST_W-1:0]      dest_offset;
    logic [cfta_pkg::SRC_OFF_W-1:0]   src_offset;
    logic [cfta_pkg::SRC_CR_W-1:0]    src_col;
    logic [cfta_pkg::SRC_CR_W-1:0]    src_row;

    modport source (output valid, output dest_offset, output src_offset,
                    output src_col, output src_row, input ready);
    modport sink (input valid, input dest_offset, input src_offset,
                  input src_col, input src_row, output ready);
endinterface

// ----- hdl/cfta_cfg.sv -----
// ----------------------------------------------------------------------------
// cfta_cfg
// Configuration registers and the values derived from them: clamped face
// sizes, face extent in the cross and the face origin.
// ----------------------------------------------------------------------------
module cfta_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cfta_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfta_pkg::CFG_DATA_W-1:0]     cfg_data,
    output cfta_pkg::cfg_t                      cfg
);

    logic [cfta_pkg::FSEL_W-1:0]  face_select_reg, face_select_next;
    logic [cfta_pkg::SIZE_W-1:0]  face_size_x_reg, face_size_x_next;
    logic [cfta_pkg::SIZE_W-1:0]  face_size_y_reg, face_size_y_next;
    logic [cfta_pkg::ISX_W-1:0]   image_size_x_reg, image_size_x_next;
    logic [cfta_pkg::ISY_W-1:0]   image_size_y_reg, image_size_y_next;
    logic [cfta_pkg::BPT_W-1:0]   bpt_reg, bpt_next;
    logic                         warp_enable_reg, warp_enable_next;
    logic [cfta_pkg::EXT_W-1:0]   ext_y_reg, ext_y_next;
    logic [cfta_pkg::ISY_W+cfta_pkg::DIV3_W-1:0] third_prod;
    logic [cfta_pkg::EXT_W-1:0]   ext_x;

    function automatic logic [cfta_pkg::SIZE_W-1:0] clamp_size(
        logic [cfta_pkg::SIZE_W-1:0] s);
        logic [cfta_pkg::SIZE_W-1:0] r;
        if (s == '0) begin
            r = cfta_pkg::SIZE_W'(1);
        end
        else if (s > cfta_pkg::SIZE_W'(cfta_pkg::MAX_FACE_SIZE)) begin
            r = cfta_pkg::SIZE_W'(cfta_pkg::MAX_FACE_SIZE);
        end
        else begin
            r = s;
        end
        return r;
    endfunction

    always_comb
    begin
        face_select_next  = face_select_reg;
        face_size_x_next  = face_size_x_reg;
        face_size_y_next  = face_size_y_reg;
        image_size_x_next = image_size_x_reg;
        image_size_y_next = image_size_y_reg;
        bpt_next          = bpt_reg;
        warp_enable_next  = warp_enable_reg;
        if (cfg_we) begin
            case (cfta_pkg::reg_index_t'(cfg_index))
                cfta_pkg::REG_FACE_SELECT:  face_select_next  = cfg_data[cfta_pkg::FSEL_W-1:0];
                cfta_pkg::REG_FACE_SIZE_X:  face_size_x_next  = cfg_data[cfta_pkg::SIZE_W-1:0];
                cfta_pkg::REG_FACE_SIZE_Y:  face_size_y_next  = cfg_data[cfta_pkg::SIZE_W-1:0];
                cfta_pkg::REG_IMAGE_SIZE_X: image_size_x_next = cfg_data[cfta_pkg::ISX_W-1:0];
                cfta_pkg::REG_IMAGE_SIZE_Y: image_size_y_next = cfg_data[cfta_pkg::ISY_W-1:0];
                cfta_pkg::REG_BYTES_TEXEL:  bpt_next          = cfg_data[cfta_pkg::BPT_W-1:0];
                cfta_pkg::REG_WARP_ENABLE:  warp_enable_next  = cfg_data[0];
                default: ;
            endcase
        end
        // A third of the image height, kept ready for the row extent.
        third_prod = image_size_y_next * cfta_pkg::DIV3_RECIP;
        ext_y_next = third_prod[cfta_pkg::DIV3_SHIFT +: cfta_pkg::EXT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            face_select_reg  <= '0;
            face_size_x_reg  <= cfta_pkg::RST_FACE_SIZE;
            face_size_y_reg  <= cfta_pkg::RST_FACE_SIZE;
            image_size_x_reg <= cfta_pkg::RST_IMAGE_X;
            image_size_y_reg <= cfta_pkg::RST_IMAGE_Y;
            bpt_reg          <= cfta_pkg::RST_BPT;
            warp_enable_reg  <= 1'b0;
            ext_y_reg        <= cfta_pkg::RST_EXT_Y;
        end
        else begin
            face_select_reg  <= face_select_next;
            face_size_x_reg  <= face_size_x_next;
            face_size_y_reg  <= face_size_y_next;
            image_size_x_reg <= image_size_x_next;
            image_size_y_reg <= image_size_y_next;
            bpt_reg          <= bpt_next;
            warp_enable_reg  <= warp_enable_next;
            ext_y_reg        <= ext_y_next;
        end
    end

    assign ext_x = image_size_x_reg[cfta_pkg::ISX_W-1:2];

    always_comb
    begin
        cfg.face_size_x     = face_size_x_reg;
        cfg.div_size_x      = clamp_size(face_size_x_reg);
        cfg.div_size_y      = clamp_size(face_size_y_reg);
        cfg.ext_x           = ext_x;
        cfg.ext_y           = ext_y_reg;
        cfg.image_size_x    = image_size_x_reg;
        cfg.bytes_per_texel = bpt_reg;
        cfg.warp_enable     = warp_enable_reg;
        case (cfta_pkg::face_t'(face_select_reg))
            cfta_pkg::FACE_RIGHT:
            begin
                cfg.org_x = cfta_pkg::ORGX_W'({ext_x, 1'b0});
                cfg.org_y = cfta_pkg::ORGY_W'(ext_y_reg);
            end
            cfta_pkg::FACE_LEFT:
            begin
                cfg.org_x = '0;
                cfg.org_y = cfta_pkg::ORGY_W'(ext_y_reg);
            end
            cfta_pkg::FACE_TOP:
            begin
                cfg.org_x = cfta_pkg::ORGX_W'(ext_x);
                cfg.org_y = '0;
            end
            cfta_pkg::FACE_BOTTOM:
            begin
                cfg.org_x = cfta_pkg::ORGX_W'(ext_x);
                cfg.org_y = cfta_pkg::ORGY_W'({ext_y_reg, 1'b0});
            end
            cfta_pkg::FACE_FRONT:
            begin
                cfg.org_x = cfta_pkg::ORGX_W'(ext_x);
                cfg.org_y = cfta_pkg::ORGY_W'(ext_y_reg);
            end
            cfta_pkg::FACE_BACK:
            begin
                cfg.org_x = cfta_pkg::ORGX_W'({ext_x, 1'b0}) + cfta_pkg::ORGX_W'(ext_x);
                cfg.org_y = cfta_pkg::ORGY_W'(ext_y_reg);
            end
            default:
            begin
                cfg.org_x = '0;
                cfg.org_y = '0;
            end
        endcase
    end

endmodule

// ----- hdl/cfta_div_slice.sv -----
// ----------------------------------------------------------------------------
// cfta_div_slice
// One registered slice of the fraction divider: a few quotient bits of
// pos / face_size for both axes.
// ----------------------------------------------------------------------------
module cfta_div_slice (
    input  logic                          clk,
    input  logic                          load,
    input  logic [cfta_pkg::SIZE_W-1:0]   size_x,
    input  logic [cfta_pkg::SIZE_W-1:0]   size_y,
    input  cfta_pkg::div_t                din,
    output cfta_pkg::div_t                dout
);

    cfta_pkg::div_t div_reg, div_next;

    always_comb
    begin
        div_next.x = cfta_pkg::div_steps(din.x, size_x);
        div_next.y = cfta_pkg::div_steps(din.y, size_y);
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            div_reg <= div_next;
        end
    end

    assign dout = div_reg;

endmodule

// ----- hdl/cfta_warp.sv -----
// ----------------------------------------------------------------------------
// cfta_warp
// Tangent warp of one face coordinate: table lookup of two neighbors,
// linear interpolation and mapping back to 0..1, or the coordinate unchanged with the warp off.
// ----------------------------------------------------------------------------
module cfta_warp (
    input  logic                       clk,
    input  logic [1:0]                 load,
    input  cfta_pkg::div_axis_t        quo,
    input  logic                       warp_enable,
    output logic [cfta_pkg::U_W-1:0]   u_out
);

    localparam int U_W = cfta_pkg::U_W;
    localparam int SH  = cfta_pkg::WARP_SHIFT;

    logic [U_W-1:0]                    u_in;
    logic                              neg;
    logic [U_W:0]                      dbl;
    logic [U_W-1:0]                    t;
    logic [cfta_pkg::WARP_ADDR_W-1:0]  addr_a, addr_b;

    logic [U_W-1:0]                    lut_a_reg, lut_b_reg;
    logic [U_W-1:0]                    u_reg;
    logic                              neg_reg;
    logic [SH-1:0]                     frac_reg;

    logic signed [U_W:0]               diff;
    logic signed [U_W+SH+1:0]          prod;
    logic signed [U_W+SH+1:0]          prod_sh;
    logic [U_W:0]                      v_sum;
    logic [U_W:0]                      folded;
    logic [U_W-1:0]                    u_next, u_warp_reg;

    // Stage one: fold about the face center and address the table.
    always_comb
    begin
        u_in = quo.sat ? cfta_pkg::ONE_Q : {1'b0, quo.quo};
        neg  = (u_in < cfta_pkg::HALF_Q);
        dbl  = {u_in, 1'b0};
        t    = neg ? U_W'({1'b0, cfta_pkg::ONE_Q} - dbl)
                   : U_W'(dbl - {1'b0, cfta_pkg::ONE_Q});
        addr_a = t[U_W-1:SH];
        addr_b = (addr_a == cfta_pkg::WARP_ADDR_W'(cfta_pkg::WARP_ENTRIES))
                 ? addr_a : addr_a + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load[0]) begin
            lut_a_reg <= cfta_pkg::WARP_LUT[addr_a];
            lut_b_reg <= cfta_pkg::WARP_LUT[addr_b];
            u_reg     <= u_in;
            neg_reg   <= neg;
            frac_reg  <= t[SH-1:0];
        end
    end

    // Stage two: interpolate and unfold.
    always_comb
    begin
        diff    = $signed({1'b0, lut_b_reg}) - $signed({1'b0, lut_a_reg});
        prod    = diff * $signed({1'b0, frac_reg});
        prod_sh = prod >>> SH;
        v_sum   = {1'b0, lut_a_reg} + prod_sh[U_W:0];
        folded  = neg_reg ? ({1'b0, cfta_pkg::ONE_Q} - {1'b0, v_sum[U_W-1:0]})
                          : ({1'b0, cfta_pkg::ONE_Q} + {1'b0, v_sum[U_W-1:0]});
        u_next  = warp_enable ? folded[U_W:1] : u_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[1]) begin
            u_warp_reg <= u_next;
        end
    end

    assign u_out = u_warp_reg;

endmodule

// ----- hdl/cfta_addr.sv -----
// ----------------------------------------------------------------------------
// cfta_addr
// Scales the face coordinates to the face extent, saturates, adds the face
// origin and forms the byte offset of the source texel.
// ----------------------------------------------------------------------------
module cfta_addr (
    input  logic                             clk,
    input  logic [2:0]                       load,
    input  logic [cfta_pkg::U_W-1:0]         u_x,
    input  logic [cfta_pkg::U_W-1:0]         u_y,
    input  cfta_pkg::cfg_t                   cfg,
    output logic [cfta_pkg::SRC_OFF_W-1:0]   src_offset,
    output logic [cfta_pkg::SRC_CR_W-1:0]    src_col,
    output logic [cfta_pkg::SRC_CR_W-1:0]    src_row
);

    localparam int PROD_W = cfta_pkg::EXT_W + cfta_pkg::U_W;
    localparam int C_W    = PROD_W - cfta_pkg::FRAC_BITS;

    logic [PROD_W-1:0]               prod_x, prod_y;
    logic [cfta_pkg::EXT_W-1:0]      cx, cy;
    logic [cfta_pkg::COL_W-1:0]      col_next;
    logic [cfta_pkg::ROW_W-1:0]      row_next;
    logic [cfta_pkg::COL_W-1:0]      col1_reg, col2_reg, col3_reg;
    logic [cfta_pkg::ROW_W-1:0]      row1_reg, row2_reg, row3_reg;
    logic [cfta_pkg::LIN_W-1:0]      lin_prod;
    logic [cfta_pkg::LIN_W-1:0]      lin_next, lin_reg;
    logic [cfta_pkg::LIN_W+cfta_pkg::BPT_W-1:0] off_full;
    logic [cfta_pkg::SRC_OFF_W-1:0]  off_reg;

    // Saturate a scaled position to extent - 1, or 0 for an empty extent.
    function automatic logic [cfta_pkg::EXT_W-1:0] sat_pos(
        logic [C_W-1:0] c, logic [cfta_pkg::EXT_W-1:0] ext);
        logic [cfta_pkg::EXT_W-1:0] r;
        if (c >= C_W'(ext)) begin
            r = (ext == '0) ? '0 : ext - 1'b1;
        end
        else begin
            r = c[cfta_pkg::EXT_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        prod_x   = cfg.ext_x * u_x;
        prod_y   = cfg.ext_y * u_y;
        cx       = sat_pos(prod_x[PROD_W-1:cfta_pkg::FRAC_BITS], cfg.ext_x);
        cy       = sat_pos(prod_y[PROD_W-1:cfta_pkg::FRAC_BITS], cfg.ext_y);
        col_next = cfg.org_x + cfta_pkg::COL_W'(cx);
        row_next = cfg.org_y + cfta_pkg::ROW_W'(cy);
    end

    always_ff @(posedge clk)
    begin
        if (load[0]) begin
            col1_reg <= col_next;
            row1_reg <= row_next;
        end
    end

    assign lin_prod = row1_reg * cfg.image_size_x;
    assign lin_next = lin_prod + cfta_pkg::LIN_W'(col1_reg);

    always_ff @(posedge clk)
    begin
        if (load[1]) begin
            lin_reg  <= lin_next;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
        end
    end

    assign off_full = lin_reg * cfg.bytes_per_texel;

    always_ff @(posedge clk)
    begin
        if (load[2]) begin
            off_reg  <= off_full[cfta_pkg::SRC_OFF_W-1:0];
            col3_reg <= col2_reg;
            row3_reg <= row2_reg;
        end
    end

    assign src_offset = off_reg;
    assign src_col    = col3_reg[cfta_pkg::SRC_CR_W-1:0];
    assign src_row    = row3_reg;

endmodule

// ----- hdl/cube_face_texel_address.sv -----
// ----------------------------------------------------------------------------
// cube_face_texel_address
// Address generator for extracting one face of a 4x3 cross cube map: face
// buffer offset and nearest source texel for each destination texel.
// ----------------------------------------------------------------------------
//  Channel  Kind      Payload
//  req      sink      dest_col, dest_row
//  rsp      source    dest_offset, src_offset, src_col, src_row
//  cfg_*    write     cfg_index selects the register, cfg_data is written
//
// One transaction per cycle is taken unless the pipeline is full and the response side
// stalls; each passes from request to response through four fraction divider slices, two
// warp table stages and three address stages.
// After reset the registers hold their defaults and the pipeline is empty;
// no clearing pass is needed.
// A stalled stage holds its item while earlier empty stages keep filling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cube_face_texel_address (
    input  logic                                clk,
    input  logic                                rst_n,
    cfta_req_if.sink                            req,
    cfta_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [cfta_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfta_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NS   = cfta_pkg::NUM_STAGES;
    localparam int LAST = NS - 1;

    cfta_pkg::cfg_t                  cfg;
    logic [NS-1:0]                   valid_reg, valid_next, load;
    cfta_pkg::div_t                  div_stage [0:cfta_pkg::DIV_SLICES];
    logic [cfta_pkg::U_W-1:0]        u_x, u_y;
    logic [cfta_pkg::SIZE_W+cfta_pkg::POS_W-1:0] dest_prod;
    logic [cfta_pkg::DEST_W-1:0]     dest_sum;
    logic [cfta_pkg::DEST_W-1:0]     dest_reg [0:NS-1];

    cfta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage may load when it is empty or its item moves on.
    always_comb
    begin
        load[LAST] = !valid_reg[LAST] || rsp.ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = load[0] ? req.valid : valid_reg[0];
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    assign req.ready = load[0];

    // Divider setup: a position at or past the face size saturates to one.
    always_comb
    begin
        div_stage[0].x.sat = ({1'b0, req.dest_col} >= cfg.div_size_x);
        div_stage[0].x.rem = div_stage[0].x.sat ? '0 : req.dest_col;
        div_stage[0].x.quo = '0;
        div_stage[0].y.sat = ({1'b0, req.dest_row} >= cfg.div_size_y);
        div_stage[0].y.rem = div_stage[0].y.sat ? '0 : req.dest_row;
        div_stage[0].y.quo = '0;
    end

    for (genvar g = 0; g < cfta_pkg::DIV_SLICES; g++) begin : g_div
        cfta_div_slice u_div (
            .clk    (clk),
            .load   (load[g]),
            .size_x (cfg.div_size_x),
            .size_y (cfg.div_size_y),
            .din    (div_stage[g]),
            .dout   (div_stage[g+1])
        );
    end

    cfta_warp u_warp_x (
        .clk         (clk),
        .load        (load[cfta_pkg::STG_WARP +: 2]),
        .quo         (div_stage[cfta_pkg::DIV_SLICES].x),
        .warp_enable (cfg.warp_enable),
        .u_out       (u_x)
    );

    cfta_warp u_warp_y (
        .clk         (clk),
        .load        (load[cfta_pkg::STG_WARP +: 2]),
        .quo         (div_stage[cfta_pkg::DIV_SLICES].y),
        .warp_enable (cfg.warp_enable),
        .u_out       (u_y)
    );

    cfta_addr u_addr (
        .clk        (clk),
        .load       (load[cfta_pkg::STG_ADDR +: 3]),
        .u_x        (u_x),
        .u_y        (u_y),
        .cfg        (cfg),
        .src_offset (rsp.src_offset),
        .src_col    (rsp.src_col),
        .src_row    (rsp.src_row)
    );

    // Face buffer offset, formed on entry and carried along the pipeline.
    assign dest_prod = cfg.face_size_x * req.dest_row;
    assign dest_sum  = cfta_pkg::DEST_W'(dest_prod) + cfta_pkg::DEST_W'(req.dest_col);

    always_ff @(posedge clk)
    begin
        if (load[0]) begin
            dest_reg[0] <= {dest_sum[cfta_pkg::DEST_W-3:0], 2'b00};
        end
        for (int i = 1; i < NS; i++) begin
            if (load[i]) begin
                dest_reg[i] <= dest_reg[i-1];
            end
        end
    end

    assign rsp.valid       = valid_reg[LAST];
    assign rsp.dest_offset = dest_reg[LAST];

    `ASSERT_IMPLIES(a_full_when_blocked, !req.ready, &valid_reg,
        "request side blocked while a pipeline stage is empty")
    `ASSERT_NEXT(a_accept_enters, req.valid && req.ready, valid_reg[0],
        "accepted transaction did not enter the first stage")
    `ASSERT_NEXT(a_stage_holds, valid_reg[0] && !load[0], valid_reg[0],
        "stalled first stage lost its transaction")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cube face texel address generator. A
// scoreboard predicts the face buffer offset and the source texel of each
// accepted request and compares every response with the oldest prediction.
// Requests come in random bursts and the response side stalls on a changing
// pattern. The registers are rewritten only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
    import cfta_pkg::*;

    localparam int LATENCY      = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 500;

    typedef longint unsigned u64_t;

    localparam u64_t UNIT = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [DEST_W-1:0]    dest_offset;
        logic [SRC_OFF_W-1:0] src_offset;
        logic [SRC_CR_W-1:0]  src_col;
        logic [SRC_CR_W-1:0]  src_row;
    } texel_addr_t;

    class addr_scoreboard;
        u64_t              warp_table [0:WARP_ENTRIES];
        logic [FSEL_W-1:0] face_sel;
        u64_t              fsx;
        u64_t              fsy;
        u64_t              isx;
        u64_t              isy;
        u64_t              bpt;
        bit                warp_on;
        texel_addr_t       pending_addrs [$];
        int unsigned       accepted;
        int unsigned       checked;
        int unsigned       mismatches;

        function new();
            build_warp_table();
            face_sel   = 0;
            fsx        = 256;
            fsy        = 256;
            isx        = 1024;
            isy        = 768;
            bpt        = 4;
            warp_on    = 0;
            accepted   = 0;
            checked    = 0;
            mismatches = 0;
        endfunction

        // Integer CORDIC in vectoring form; the returned angle is in Q30.
        function longint arctan_q30(longint z);
            longint x;
            longint y;
            longint ang;
            longint a;
            longint dx;
            longint dy;
            int     i;
            x   = 64'sd1 <<< 30;
            y   = z;
            ang = 0;
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                a  = (i < ATAN_TAB_N) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x   = x + dx;
                    y   = y - dy;
                    ang = ang + a;
                end
                else
                begin
                    x   = x - dx;
                    y   = y + dy;
                    ang = ang - a;
                end
            end
            return ang;
        endfunction

        function void build_warp_table();
            longint z;
            longint ang;
            u64_t   v;
            int     k;
            for (k = 0; k <= WARP_ENTRIES; k++)
            begin
                z   = longint'((u64_t'(k) * K_SCALE_Q30) / WARP_ENTRIES);
                ang = arctan_q30(z);
                if (ang < 0)
                    ang = 0;
                v = (u64_t'(ang) * K_GAIN_Q30 + (64'd1 << (59 - FRAC_BITS)))
                    >> (60 - FRAC_BITS);
                warp_table[k] = (v > UNIT) ? UNIT : v;
            end
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FACE_SELECT:  face_sel = data[FSEL_W-1:0];
                REG_FACE_SIZE_X:  fsx      = u64_t'(data[SIZE_W-1:0]);
                REG_FACE_SIZE_Y:  fsy      = u64_t'(data[SIZE_W-1:0]);
                REG_IMAGE_SIZE_X: isx      = u64_t'(data[ISX_W-1:0]);
                REG_IMAGE_SIZE_Y: isy      = u64_t'(data[ISY_W-1:0]);
                REG_BYTES_TEXEL:  bpt      = u64_t'(data[BPT_W-1:0]);
                REG_WARP_ENABLE:  warp_on  = data[0];
                default: ;
            endcase
        endfunction

        function u64_t fit_size(u64_t s);
            if (s == 0)
                return 1;
            return (s > MAX_FACE_SIZE) ? MAX_FACE_SIZE : s;
        endfunction

        // The warp is odd around the face center, so only |t| is looked up.
        function u64_t warp_coord(u64_t u);
            bit   below;
            u64_t t;
            u64_t p;
            u64_t idx;
            u64_t fr;
            u64_t v;
            below = (u < (UNIT >> 1));
            t     = below ? UNIT - 2 * u : 2 * u - UNIT;
            p     = t * WARP_ENTRIES;
            idx   = p >> FRAC_BITS;
            fr    = p & (UNIT - 1);
            if (idx >= WARP_ENTRIES)
                v = warp_table[WARP_ENTRIES];
            else
                v = (warp_table[idx] * (UNIT - fr) + warp_table[idx + 1] * fr) >> FRAC_BITS;
            return below ? (UNIT - v) >> 1 : (UNIT + v) >> 1;
        endfunction

        function u64_t texel_pick(u64_t pos, u64_t size, u64_t extent);
            u64_t u;
            u64_t c;
            u = (pos << FRAC_BITS) / fit_size(size);
            if (u > UNIT)
                u = UNIT;
            if (warp_on)
                u = warp_coord(u);
            if (extent == 0)
                return 0;
            c = (extent * u) >> FRAC_BITS;
            return (c > extent - 1) ? extent - 1 : c;
        endfunction

        function void note_request(logic [POS_W-1:0] dcol, logic [POS_W-1:0] drow);
            u64_t        qx;
            u64_t        qy;
            u64_t        ox;
            u64_t        oy;
            u64_t        col;
            u64_t        row;
            texel_addr_t addr;
            qx = isx / 4;
            qy = isy / 3;
            ox = 0;
            oy = 0;
            case (face_sel)
                FACE_RIGHT:
                begin
                    ox = 2 * qx;
                    oy = qy;
                end
                FACE_LEFT:   oy = qy;
                FACE_TOP:    ox = qx;
                FACE_BOTTOM:
                begin
                    ox = qx;
                    oy = 2 * qy;
                end
                FACE_FRONT:
                begin
                    ox = qx;
                    oy = qy;
                end
                FACE_BACK:
                begin
                    ox = 3 * qx;
                    oy = qy;
                end
                default: ;
            endcase
            col = ox + texel_pick(u64_t'(dcol), fsx, qx);
            row = oy + texel_pick(u64_t'(drow), fsy, qy);
            addr.dest_offset = DEST_W'(4 * (u64_t'(dcol) + fsx * u64_t'(drow)));
            addr.src_offset  = SRC_OFF_W'(bpt * (col + row * isx));
            addr.src_col     = SRC_CR_W'(col);
            addr.src_row     = SRC_CR_W'(row);
            pending_addrs.push_back(addr);
            accepted++;
        endfunction

        function void check_response(texel_addr_t got);
            texel_addr_t exp_addr;
            if (pending_addrs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with nothing outstanding: dest %0d src %0d (%0d,%0d)",
                             $time, got.dest_offset, got.src_offset, got.src_col, got.src_row);
                return;
            end
            exp_addr = pending_addrs.pop_front();
            checked++;
            if (got.dest_offset != exp_addr.dest_offset
                || got.src_offset != exp_addr.src_offset
                || got.src_col != exp_addr.src_col
                || got.src_row != exp_addr.src_row)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: dest %0d/%0d src %0d/%0d col %0d/%0d row %0d/%0d (exp/got)",
                             $time, exp_addr.dest_offset, got.dest_offset,
                             exp_addr.src_offset, got.src_offset,
                             exp_addr.src_col, got.src_col, exp_addr.src_row, got.src_row);
            end
        endfunction

        function int pending();
            return pending_addrs.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cfta_req_if req_ch ();
    cfta_rsp_if rsp_ch ();

    addr_scoreboard sb = new();

    int unsigned settings_run;
    int unsigned warp_settings;

    cube_face_texel_address DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Everything below is sampled at the edge, before the nonblocking updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_register(cfg_index, cfg_data);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.dest_col, req_ch.dest_row);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.dest_offset, rsp_ch.src_offset,
                                   rsp_ch.src_col, rsp_ch.src_row});
        end
    end

    // Receiver: switches between always ready, light and heavy random stalls,
    // and a fixed duty pattern.
    initial
    begin
        int          mode;
        int          left;
        int unsigned tick;
        rsp_ch.ready = 1'b0;
        mode         = 0;
        left         = 0;
        tick         = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((tick % 7) < 3);
            endcase
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("no completion within %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic send_texel(input logic [POS_W-1:0] dcol, input logic [POS_W-1:0] drow);
        req_ch.valid    <= 1'b1;
        req_ch.dest_col <= dcol;
        req_ch.dest_row <= drow;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // The extra edge lets the monitor log the last transaction before the count is read.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic apply_setting(input int unsigned face, input int unsigned size_x,
                                 input int unsigned size_y, input int unsigned img_x,
                                 input int unsigned img_y, input int unsigned bytes,
                                 input int unsigned warp);
        write_reg(REG_FACE_SELECT, face);
        write_reg(REG_FACE_SIZE_X, size_x);
        write_reg(REG_FACE_SIZE_Y, size_y);
        write_reg(REG_IMAGE_SIZE_X, img_x);
        write_reg(REG_IMAGE_SIZE_Y, img_y);
        write_reg(REG_BYTES_TEXEL, bytes);
        write_reg(REG_WARP_ENABLE, warp);
        cfg_we <= 1'b0;
        settings_run++;
        if (warp[0])
            warp_settings++;
    endtask

    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(MAX_FACE_SIZE + 1, 8191);
        if (r == 2)
            return MAX_FACE_SIZE;
        return $urandom_range(1, MAX_FACE_SIZE);
    endfunction

    task automatic random_setting();
        int unsigned img_x;
        int unsigned img_y;
        int unsigned bytes;
        int          r;
        r = $urandom_range(0, 5);
        case (r)
            0:       img_x = $urandom_range(0, 32767);
            1:       img_x = 4;
            2:       img_x = 16384;
            default: img_x = $urandom_range(4, 16384);
        endcase
        r = $urandom_range(0, 5);
        case (r)
            0:       img_y = $urandom_range(0, 16383);
            1:       img_y = 3;
            2:       img_y = 12288;
            default: img_y = $urandom_range(3, 12288);
        endcase
        bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        apply_setting($urandom_range(0, 7), pick_size(), pick_size(), img_x, img_y,
                      bytes, $urandom_range(0, 1));
    endtask

    // Mostly texels inside the face, the rest anywhere in the 12-bit range.
    task automatic pick_texel(output logic [POS_W-1:0] dcol, output logic [POS_W-1:0] drow);
        u64_t lim_x;
        u64_t lim_y;
        lim_x = sb.fit_size(sb.fsx);
        lim_y = sb.fit_size(sb.fsy);
        if (lim_x > 4096)
            lim_x = 4096;
        if (lim_y > 4096)
            lim_y = 4096;
        if ($urandom_range(0, 4) == 0)
            dcol = POS_W'($urandom_range(0, 4095));
        else
            dcol = POS_W'($urandom_range(0, int'(lim_x) - 1));
        if ($urandom_range(0, 4) == 0)
            drow = POS_W'($urandom_range(0, 4095));
        else
            drow = POS_W'($urandom_range(0, int'(lim_y) - 1));
    endtask

    task automatic run_phase(input int count);
        int               done;
        int               burst;
        int               gap;
        int               k;
        logic [POS_W-1:0] dcol;
        logic [POS_W-1:0] drow;
        done = 0;
        while (done < count)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
            for (k = 0; k < burst && done < count; k++)
            begin
                pick_texel(dcol, drow);
                send_texel(dcol, drow);
                done++;
            end
        end
    endtask

    initial
    begin
        int unsigned start_count;
        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.dest_col = '0;
        req_ch.dest_row = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        settings_run    = 0;
        warp_settings   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset, one texel past the face edge.
        send_texel(0, 0);
        send_texel(255, 255);
        send_texel(256, 300);
        wait_idle();

        apply_setting(FACE_RIGHT, 256, 256, 1024, 768, 4, 0);
        send_texel(0, 0);
        send_texel(255, 255);
        wait_idle();

        apply_setting(FACE_LEFT, 256, 256, 1024, 768, 4, 1);
        send_texel(0, 0);
        send_texel(127, 128);
        send_texel(255, 255);
        wait_idle();

        // Zero width taken as one, oversize height capped, smallest cross.
        apply_setting(FACE_TOP, 0, 8191, 4, 3, 0, 1);
        send_texel(0, 0);
        send_texel(4095, 4095);
        wait_idle();

        apply_setting(FACE_BOTTOM, 1, 1, 16384, 12288, 7, 0);
        send_texel(0, 0);
        send_texel(1, 1);
        send_texel(4095, 0);
        wait_idle();

        apply_setting(FACE_FRONT, 4096, 4096, 32767, 16383, 7, 1);
        send_texel(4095, 4095);
        send_texel(2048, 0);
        send_texel(0, 4095);
        wait_idle();

        // An image this small leaves a face extent of zero.
        apply_setting(FACE_BACK, 8191, 0, 0, 0, 1, 0);
        send_texel(100, 200);
        send_texel(4095, 4095);
        wait_idle();

        // Face codes past the last face fall back to the cross origin.
        apply_setting(3'd6, 256, 256, 1024, 768, 3, 1);
        send_texel(300, 10);
        send_texel(128, 64);
        wait_idle();

        apply_setting(3'd7, 4096, 4096, 16384, 12288, 4, 0);
        send_texel(4095, 4095);
        send_texel(0, 0);
        wait_idle();

        start_count = sb.accepted;
        while (sb.accepted - start_count < RANDOM_ITEMS)
        begin
            random_setting();
            run_phase($urandom_range(15, 45));
            wait_idle();
        end

        repeat (4 * LATENCY) @(posedge clk);
        $display("checked %0d texel addresses under %0d register settings, %0d with warp",
                 sb.checked, settings_run, warp_settings);
        $display("covered all face codes, degenerate and maximum sizes, bursts and stalls");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
